/* rtl/core/id3fw_pkg.sv */
// shared types, constants and helpers for the id3v2 frame walker
package id3fw_pkg;

    localparam int unsigned ADDR_W = 3;

    // register word index taken from paddr[2]
    typedef enum logic [0:0] {
        REG_MODE   = 1'b0,
        REG_WANTED = 1'b1
    } t_reg_idx;

    localparam logic [31:0] WANTED_RESET = 32'h5449_5432;
    localparam logic [31:0] ID_APIC      = 32'h4150_4943;

    localparam logic [7:0]  ID_FIRST_MIN = 8'd65;
    localparam logic [7:0]  ID_FIRST_MAX = 8'd91;
    localparam logic [7:0]  CHAR_MIN     = 8'd32;
    localparam logic [7:0]  CHAR_MAX     = 8'd127;

    localparam logic [31:0] FRAME_HDR_BYTES = 32'd10;
    localparam logic [31:0] EXT_HDR_BYTES   = 32'd6;
    localparam int unsigned EXT_FLAG_BIT    = 6;

    // byte positions inside the headers
    localparam logic [3:0] TAG_FLAGS_POS = 4'd5;
    localparam logic [3:0] TAG_SIZE_POS  = 4'd6;
    localparam logic [3:0] TAG_LAST_POS  = 4'd9;
    localparam logic [3:0] EXT_SIZE_LAST = 4'd3;
    localparam logic [3:0] EXT_LAST_POS  = 4'd5;
    localparam logic [3:0] FR_ID_LAST    = 4'd3;
    localparam logic [3:0] FR_SIZE_LAST  = 4'd7;
    localparam logic [3:0] FR_LAST_POS   = 4'd9;

    typedef enum logic [1:0] {
        EV_START = 2'd0,
        EV_CHAR  = 2'd1,
        EV_END   = 2'd2,
        EV_DONE  = 2'd3
    } t_event;

    typedef enum logic [5:0] {
        PH_HDR     = 6'b000001,
        PH_EXTHDR  = 6'b000010,
        PH_EXTSKIP = 6'b000100,
        PH_FRHDR   = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic       start_of_tag;
        logic [7:0] data_byte;
    } t_in_beat;

    typedef struct packed {
        t_event      event_res;
        logic [31:0] frame_id;
        logic [7:0]  char_value;
        logic        last;
    } t_out_beat;

    typedef struct packed {
        t_event      event_res;
        logic [31:0] frame_id;
        logic [7:0]  char_value;
    } t_res_item;

    // results of one byte, oldest in slot 0
    typedef struct packed {
        logic                load;
        logic [1:0]          cnt;
        t_res_item [2:0]     items;
    } t_res_bundle;

    typedef struct packed {
        logic        mode;
        logic [31:0] wanted_id;
    } t_cfg;

    // size bytes are weighted by 128 and kept to 30 bits
    function automatic logic [29:0] size_step(input logic [29:0] acc, input logic [7:0] b);
        size_step = {acc[22:0], 7'b0} + {22'b0, b};
    endfunction

endpackage

/* rtl/core/id3fw_cfg_regs.sv */
// apb register block: mode and wanted frame id
module id3fw_cfg_regs
    import id3fw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic        r_mode;
    logic [31:0] r_wanted;
    logic        wr_en;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_wanted <= WANTED_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:   r_mode   <= pwdata[0];
                REG_WANTED: r_wanted <= pwdata;
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:   prdata = {31'b0, r_mode};
            REG_WANTED: prdata = r_wanted;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg.mode      = r_mode;
    assign o_cfg.wanted_id = r_wanted;

endmodule

/* rtl/core/id3fw_parse_core.sv */
// input register and single-pass parse step producing up to three results per byte
module id3fw_parse_core
    import id3fw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_beat    i_in_data,
    output logic        o_in_stall,
    input  t_cfg        i_cfg,
    input  logic        i_q_free,
    output t_res_bundle o_bundle
);

    logic        r_in_valid;
    t_in_beat    r_in;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_bidx,     n_bidx;
    logic        r_ext_flag, n_ext_flag;
    logic [29:0] r_tag_size, n_tag_size;
    logic [31:0] r_cons,     n_cons;
    logic [31:0] r_id,       n_id;
    logic [29:0] r_left,     n_left;
    logic        r_emit,     n_emit;

    logic        go;

    // state seen by this byte, after an optional restart
    t_phase      c_phase;
    logic [3:0]  c_bidx;
    logic        c_ext_flag;
    logic [29:0] c_tag_size;
    logic [31:0] c_cons;
    logic [31:0] c_id;
    logic [29:0] c_left;
    logic        c_emit;

    logic [7:0]  b;
    logic [29:0] left_dec;
    logic [29:0] left_base;
    logic [31:0] id_base;
    logic [31:0] cons_sum;
    logic [31:0] chk_cons;
    logic        do_check;
    logic        do_finish;
    logic        ev_a;
    t_res_item   item_a;
    logic        ev_end;
    logic        ev_done;
    t_res_item   item_end;
    t_res_item   item_done;

    assign go         = r_in_valid && i_q_free;
    assign o_in_stall = r_in_valid && !i_q_free;
    assign b          = r_in.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_comb begin
        if (r_in.start_of_tag) begin
            c_phase    = PH_HDR;
            c_bidx     = '0;
            c_ext_flag = 1'b0;
            c_tag_size = '0;
            c_cons     = '0;
            c_id       = '0;
            c_left     = '0;
            c_emit     = 1'b0;
        end else begin
            c_phase    = r_phase;
            c_bidx     = r_bidx;
            c_ext_flag = r_ext_flag;
            c_tag_size = r_tag_size;
            c_cons     = r_cons;
            c_id       = r_id;
            c_left     = r_left;
            c_emit     = r_emit;
        end
    end

    always_comb begin
        n_phase    = c_phase;
        n_bidx     = c_bidx;
        n_ext_flag = c_ext_flag;
        n_tag_size = c_tag_size;
        n_cons     = c_cons;
        n_id       = c_id;
        n_left     = c_left;
        n_emit     = c_emit;

        left_dec  = c_left - 30'd1;
        left_base = (c_bidx == 4'd0) ? 30'd0 : c_left;
        id_base   = (c_bidx == 4'd0) ? 32'd0 : c_id;
        cons_sum  = '0;
        chk_cons  = c_cons;
        do_check  = 1'b0;
        do_finish = 1'b0;
        ev_a      = 1'b0;
        item_a    = '{event_res: EV_START, frame_id: c_id, char_value: 8'd0};
        ev_end    = 1'b0;
        ev_done   = 1'b0;

        unique case (c_phase)
            PH_HDR: begin
                if (c_bidx == TAG_FLAGS_POS) begin
                    n_ext_flag = b[EXT_FLAG_BIT];
                end else if (c_bidx >= TAG_SIZE_POS) begin
                    n_tag_size = size_step(c_tag_size, b);
                end
                if (c_bidx >= TAG_LAST_POS) begin
                    n_cons  = '0;
                    n_bidx  = '0;
                    n_left  = '0;
                    n_phase = n_ext_flag ? PH_EXTHDR : PH_FRHDR;
                end else begin
                    n_bidx = c_bidx + 4'd1;
                end
            end
            PH_EXTHDR: begin
                if (c_bidx <= EXT_SIZE_LAST) begin
                    n_left = size_step(left_base, b);
                end
                if (c_bidx >= EXT_LAST_POS) begin
                    cons_sum = c_cons + EXT_HDR_BYTES + {2'b0, n_left};
                    n_cons   = cons_sum;
                    if (n_left == 30'd0) begin
                        do_check = 1'b1;
                        chk_cons = cons_sum;
                    end else begin
                        n_phase = PH_EXTSKIP;
                        n_bidx  = '0;
                    end
                end else begin
                    n_bidx = c_bidx + 4'd1;
                end
            end
            PH_EXTSKIP: begin
                n_left = left_dec;
                if (left_dec == 30'd0) begin
                    do_check = 1'b1;
                end
            end
            PH_FRHDR: begin
                if (c_bidx <= FR_ID_LAST) begin
                    n_id = {id_base[23:0], b};
                    if (c_bidx == 4'd0) begin
                        n_left = '0;
                    end
                end else if (c_bidx <= FR_SIZE_LAST) begin
                    n_left = size_step(c_left, b);
                end
                if (c_bidx >= FR_LAST_POS) begin
                    // header complete: account for it and pick the frame
                    cons_sum = c_cons + FRAME_HDR_BYTES + {2'b0, c_left};
                    n_cons   = cons_sum;
                    chk_cons = cons_sum;
                    if (!i_cfg.mode && c_id != ID_APIC
                            && !(c_id[31:24] >= ID_FIRST_MIN && c_id[31:24] <= ID_FIRST_MAX)) begin
                        // unknown id in show-all mode ends the walk
                        n_emit  = 1'b0;
                        ev_done = 1'b1;
                        n_phase = PH_DONE;
                        n_bidx  = '0;
                    end else begin
                        if (i_cfg.mode) begin
                            n_emit = (c_id == i_cfg.wanted_id);
                        end else begin
                            n_emit = (c_id != ID_APIC);
                        end
                        ev_a = n_emit;
                        if (c_left == 30'd0) begin
                            do_finish = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                            n_bidx  = '0;
                        end
                    end
                end else begin
                    n_bidx = c_bidx + 4'd1;
                end
            end
            PH_PAYLOAD: begin
                if (c_emit && b >= CHAR_MIN && b <= CHAR_MAX) begin
                    ev_a   = 1'b1;
                    item_a = '{event_res: EV_CHAR, frame_id: c_id, char_value: b};
                end
                n_left = left_dec;
                if (left_dec == 30'd0) begin
                    do_finish = 1'b1;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        if (do_finish) begin
            ev_end   = n_emit;
            n_emit   = 1'b0;
            do_check = 1'b1;
        end
        if (do_check) begin
            n_bidx = '0;
            if (chk_cons > {2'b0, c_tag_size}) begin
                ev_done = 1'b1;
                n_phase = PH_DONE;
            end else begin
                n_phase = PH_FRHDR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR;
            r_bidx     <= '0;
            r_ext_flag <= 1'b0;
            r_tag_size <= '0;
            r_cons     <= '0;
            r_id       <= '0;
            r_left     <= '0;
            r_emit     <= 1'b0;
        end else if (go) begin
            r_phase    <= n_phase;
            r_bidx     <= n_bidx;
            r_ext_flag <= n_ext_flag;
            r_tag_size <= n_tag_size;
            r_cons     <= n_cons;
            r_id       <= n_id;
            r_left     <= n_left;
            r_emit     <= n_emit;
        end
    end

    // order is start or char, then end, then tag done
    assign item_end  = '{event_res: EV_END, frame_id: c_id, char_value: 8'd0};
    assign item_done = '{event_res: EV_DONE, frame_id: 32'd0, char_value: 8'd0};

    always_comb begin
        o_bundle.load = go;
        o_bundle.cnt  = {1'b0, ev_a} + {1'b0, ev_end} + {1'b0, ev_done};
        o_bundle.items[0] = ev_a ? item_a : (ev_end ? item_end : item_done);
        o_bundle.items[1] = (ev_a && ev_end) ? item_end : item_done;
        o_bundle.items[2] = item_done;
    end

endmodule

/* rtl/core/id3fw_result_queue.sv */
// three-slot result register that hands out one beat per cycle while the output is not stalled
module id3fw_result_queue
    import id3fw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_res_bundle i_bundle,
    output logic        o_free,
    output logic        o_out_valid,
    output t_out_beat   o_out_data,
    input  logic        i_out_stall
);

    logic [1:0]      r_cnt;
    t_res_item [2:0] r_slot;
    logic            take;

    assign o_out_valid = (r_cnt != 2'd0);
    assign take        = o_out_valid && !i_out_stall;
    assign o_free      = (r_cnt == 2'd0) || (r_cnt == 2'd1 && take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_bundle.load) begin
            r_cnt <= i_bundle.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_bundle.load) begin
            r_slot <= i_bundle.items;
        end else if (take) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
    end

    assign o_out_data.event_res  = r_slot[0].event_res;
    assign o_out_data.frame_id   = r_slot[0].frame_id;
    assign o_out_data.char_value = r_slot[0].char_value;
    assign o_out_data.last       = (r_cnt == 2'd1);

endmodule

/* rtl/core/id3v2_frame_walker_unit.sv */
// top level of the id3v2 tag frame walker
// takes one file byte per beat and walks the tag header, an optional extended
// header and the 10-byte frame headers, giving frame start, payload character,
// frame end and tag done beats. a byte is taken every cycle as long as it
// causes at most one result and the output is not stalled; a byte that
// causes two or three results (a frame header of an empty frame, the last
// payload byte of a frame) holds the input side while the result register
// hands them out one beat per cycle, as long as the output is not stalled.
// the parse step works straight off the input register and loads the result
// register once it is free, so a byte passes the input register and then
// the result register. set mode and wanted_id over apb only while no byte is
// in flight; they are sampled as each frame header completes.
module id3v2_frame_walker_unit
    import id3fw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_in_valid,
    input  t_in_beat          i_in_data,
    output logic              o_in_stall,
    // result output
    output logic              o_out_valid,
    output t_out_beat         o_out_data,
    input  logic              i_out_stall,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg        cfg;
    t_res_bundle bundle;
    logic        q_free;

    // mode at word 0, wanted frame id at word 1
    id3fw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register plus the per-byte parse step
    id3fw_parse_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg      (cfg),
        .i_q_free   (q_free),
        .o_bundle   (bundle)
    );

    // result register, drained one beat per cycle while the output is not stalled, with last on the final one
    id3fw_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bundle    (bundle),
        .o_free      (q_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

/* rtl/core/id3fw_port_checker.sv */
// port-level checks for the frame walker and their bind
module id3fw_port_checker
    import id3fw_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_beat o_out_data,
    input logic      i_out_stall
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // tag done closes a byte's results and carries no id
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == EV_DONE
            |-> o_out_data.last && o_out_data.frame_id == 32'd0)
        else $error("tag done not last or id not zero");

    // characters lie in 32 to 127, other beats carry no character
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res == EV_CHAR
            |-> o_out_data.char_value >= CHAR_MIN && o_out_data.char_value <= CHAR_MAX)
        else $error("payload character out of range");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.event_res != EV_CHAR |-> o_out_data.char_value == 8'd0)
        else $error("non-character beat has a character");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result beat right after reset");

endmodule

bind id3v2_frame_walker_unit id3fw_port_checker u_port_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
